// ----- design/hac_pkg.sv -----
// shared types and constants for the heading align controller
package hac_pkg;

  localparam int ANGLE_W   = 15;
  localparam int ERR_W     = 17;
  localparam int RATE_W    = 16;
  localparam int PROD_W    = 30;
  localparam int GAIN_W    = 12;
  localparam int GAIN_FRAC = 8;
  localparam int SPEED_W   = 15;
  localparam int THRESH_W  = 14;
  localparam int SETTLE_W  = 8;
  localparam int TICK_BITS = 16;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 16;

  localparam logic signed [ERR_W-1:0] PI_Q     = 17'sd12868;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q = 17'sd25736;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_HALT   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MODE_ALIGN   = 3'd0,
    CFG_HEADING_GOAL = 3'd1,
    CFG_GAIN         = 3'd2,
    CFG_MAX_SPEED    = 3'd3,
    CFG_THRESHOLD    = 3'd4,
    CFG_SETTLE       = 3'd5,
    CFG_ODOM_TIMEOUT = 3'd6,
    CFG_RUN_TIMEOUT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] heading_goal;
    logic [GAIN_W-1:0]         gain;
    logic [SPEED_W-1:0]        max_speed;
    logic [THRESH_W-1:0]       angle_threshold;
  } law_cfg_t;

  typedef struct packed {
    logic                     in_band;
    logic signed [RATE_W-1:0] rate;
  } law_res_t;

endpackage

// ----- design/hac_rate_law.sv -----
// heading error wrap, tolerance check and clamped proportional rate
module hac_rate_law (
  input  hac_pkg::law_cfg_t                   law_cfg,
  input  logic signed [hac_pkg::ANGLE_W-1:0]  current_yaw,
  output hac_pkg::law_res_t                   law_res
);

  localparam int SCALED_W = hac_pkg::PROD_W - hac_pkg::GAIN_FRAC;

  logic signed [hac_pkg::ERR_W-1:0]  err_raw;
  logic signed [hac_pkg::ERR_W-1:0]  err;
  logic signed [hac_pkg::ERR_W-1:0]  err_mag;
  logic signed [hac_pkg::PROD_W-1:0] prod;
  logic signed [SCALED_W-1:0]        scaled;
  logic signed [SCALED_W-1:0]        lim;
  logic signed [SCALED_W-1:0]        clamped;

  always_comb begin
    err_raw = {{2{law_cfg.heading_goal[hac_pkg::ANGLE_W-1]}}, law_cfg.heading_goal}
            - {{2{current_yaw[hac_pkg::ANGLE_W-1]}}, current_yaw};
    if (err_raw > hac_pkg::PI_Q) begin
      err = err_raw - hac_pkg::TWO_PI_Q;
    end else if (err_raw < -hac_pkg::PI_Q) begin
      err = err_raw + hac_pkg::TWO_PI_Q;
    end else begin
      err = err_raw;
    end
    err_mag = err[hac_pkg::ERR_W-1] ? -err : err;
    law_res.in_band = err_mag <= $signed({3'b000, law_cfg.angle_threshold});

    // floor of gain * err / 256
    prod   = $signed({1'b0, law_cfg.gain}) * err;
    scaled = prod[hac_pkg::PROD_W-1:hac_pkg::GAIN_FRAC];
    lim    = $signed({{(SCALED_W - hac_pkg::SPEED_W){1'b0}}, law_cfg.max_speed});
    if (scaled > lim) begin
      clamped = lim;
    end else if (scaled < -lim) begin
      clamped = -lim;
    end else begin
      clamped = scaled;
    end
    law_res.rate = clamped[hac_pkg::RATE_W-1:0];
  end

endmodule

// ----- design/heading_align_controller.sv -----
// heading align controller top level: item register, run control and result register
// Each input transfer is one request (start, yaw sample, control tick or halt) carried
// in in_tuser, with the yaw sample in in_tdata. The request sits in one input register,
// is resolved against the run state and its result lands in the output register, which
// drives out_tvalid. A request waits in the input register while the output register is
// held; one request can be taken every cycle while out_tready is high. Yaw samples give no result; start,
// tick and halt give one each. Configuration writes go through cfg_we / cfg_addr /
// cfg_wdata, take effect at once and should be made while no request is in flight.
module heading_align_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [hac_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [hac_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // yaw_sample[14:0], zero pad
  input  logic [1:0]                  in_tuser,   // req_type[1:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata   // angular_rate[15:0], status[17:16],
                                                  // odom_fresh[18], zero pad
);

  localparam logic [hac_pkg::TICK_BITS-1:0] TICK_MAX = '1;
  localparam logic [hac_pkg::SETTLE_W-1:0]  SETTLE_MAX = '1;

  // configuration
  logic                                 mode_align_r;
  logic signed [hac_pkg::ANGLE_W-1:0]   heading_goal_r;
  logic [hac_pkg::GAIN_W-1:0]           gain_r;
  logic [hac_pkg::SPEED_W-1:0]          max_speed_r;
  logic [hac_pkg::THRESH_W-1:0]         angle_threshold_r;
  logic [hac_pkg::SETTLE_W-1:0]         settle_needed_r;
  logic [hac_pkg::TICK_BITS-1:0]        odom_timeout_r;
  logic [hac_pkg::TICK_BITS-1:0]        run_timeout_r;

  // input register
  logic                                 item_v_r, item_v_nxt;
  hac_pkg::req_t                        item_req_r;
  logic signed [hac_pkg::ANGLE_W-1:0]   item_yaw_r;

  // run state
  logic                                 active_r, active_nxt;
  logic                                 have_yaw_r, have_yaw_nxt;
  logic signed [hac_pkg::ANGLE_W-1:0]   yaw_r, yaw_nxt;
  logic [hac_pkg::TICK_BITS-1:0]        elapsed_r, elapsed_nxt;
  logic [hac_pkg::TICK_BITS-1:0]        odom_age_r, odom_age_nxt;
  logic [hac_pkg::SETTLE_W-1:0]         settle_r, settle_nxt;

  // output register
  logic                                 out_v_r, out_v_nxt;
  logic signed [hac_pkg::RATE_W-1:0]    out_rate_r;
  hac_pkg::status_t                     out_status_r;
  logic                                 out_fresh_r;

  logic                                 in_xfer;
  logic                                 proc_go;
  logic                                 gen;
  logic signed [hac_pkg::RATE_W-1:0]    rate;
  hac_pkg::status_t                     status;
  logic                                 fresh;
  logic [hac_pkg::TICK_BITS-1:0]        elapsed_inc;
  logic [hac_pkg::TICK_BITS-1:0]        age_inc;
  logic [hac_pkg::SETTLE_W-1:0]         settle_inc;
  logic                                 fresh_tick;

  hac_pkg::law_cfg_t                    law_cfg;
  hac_pkg::law_res_t                    law_res;

  assign law_cfg.heading_goal    = heading_goal_r;
  assign law_cfg.gain            = gain_r;
  assign law_cfg.max_speed       = max_speed_r;
  assign law_cfg.angle_threshold = angle_threshold_r;

  hac_rate_law u_rate_law (
    .law_cfg     (law_cfg),
    .current_yaw (yaw_r),
    .law_res     (law_res)
  );

  assign proc_go   = item_v_r && (item_req_r == hac_pkg::REQ_SAMPLE || !out_v_r || out_tready);
  assign in_tready = !item_v_r || proc_go;
  assign in_xfer   = in_tvalid && in_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b00000, out_fresh_r, out_status_r, out_rate_r};

  assign elapsed_inc = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign age_inc     = (odom_age_r == TICK_MAX) ? odom_age_r : odom_age_r + 1'b1;
  assign settle_inc  = (settle_r == SETTLE_MAX) ? settle_r : settle_r + 1'b1;
  assign fresh_tick  = have_yaw_r && (age_inc <= odom_timeout_r);

  always_comb begin
    active_nxt   = active_r;
    have_yaw_nxt = have_yaw_r;
    yaw_nxt      = yaw_r;
    elapsed_nxt  = elapsed_r;
    odom_age_nxt = odom_age_r;
    settle_nxt   = settle_r;
    gen          = 1'b0;
    rate         = '0;
    status       = hac_pkg::ST_IDLE;
    fresh        = have_yaw_r && (odom_age_r <= odom_timeout_r);
    if (proc_go) begin
      case (item_req_r)
        hac_pkg::REQ_SAMPLE: begin
          if (active_r) begin
            yaw_nxt      = item_yaw_r;
            have_yaw_nxt = 1'b1;
            odom_age_nxt = '0;
          end
        end
        hac_pkg::REQ_START: begin
          gen         = 1'b1;
          active_nxt  = 1'b1;
          elapsed_nxt = '0;
          settle_nxt  = '0;
          status      = hac_pkg::ST_RUNNING;
        end
        hac_pkg::REQ_HALT: begin
          gen          = 1'b1;
          active_nxt   = 1'b0;
          have_yaw_nxt = 1'b0;
          settle_nxt   = '0;
          status       = hac_pkg::ST_IDLE;
        end
        hac_pkg::REQ_TICK: begin
          gen = 1'b1;
          if (active_r) begin
            elapsed_nxt  = elapsed_inc;
            odom_age_nxt = age_inc;
            fresh        = fresh_tick;
            status       = hac_pkg::ST_RUNNING;
            if (elapsed_inc > run_timeout_r) begin
              active_nxt   = 1'b0;
              have_yaw_nxt = 1'b0;
              settle_nxt   = '0;
              status       = hac_pkg::ST_TIMEOUT;
            end else if (!fresh_tick) begin
              settle_nxt = '0;
            end else if (law_res.in_band) begin
              if (!mode_align_r || settle_inc >= settle_needed_r) begin
                active_nxt   = 1'b0;
                have_yaw_nxt = 1'b0;
                settle_nxt   = '0;
                status       = hac_pkg::ST_SUCCESS;
              end else begin
                settle_nxt = settle_inc;
              end
            end else begin
              settle_nxt = '0;
              rate       = law_res.rate;
            end
          end
        end
        default: begin
          gen = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (in_xfer) begin
      item_v_nxt = 1'b1;
    end else if (proc_go) begin
      item_v_nxt = 1'b0;
    end else begin
      item_v_nxt = item_v_r;
    end
    if (proc_go && gen) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_align_r      <= 1'b0;
      heading_goal_r    <= '0;
      gain_r            <= 12'd256;
      max_speed_r       <= 15'd4096;
      angle_threshold_r <= 14'd143;
      settle_needed_r   <= 8'd3;
      odom_timeout_r    <= 16'd50;
      run_timeout_r     <= 16'd1000;
    end else if (cfg_we) begin
      case (hac_pkg::cfg_idx_t'(cfg_addr))
        hac_pkg::CFG_MODE_ALIGN:   mode_align_r      <= cfg_wdata[0];
        hac_pkg::CFG_HEADING_GOAL: heading_goal_r    <= cfg_wdata[hac_pkg::ANGLE_W-1:0];
        hac_pkg::CFG_GAIN:         gain_r            <= cfg_wdata[hac_pkg::GAIN_W-1:0];
        hac_pkg::CFG_MAX_SPEED:    max_speed_r       <= cfg_wdata[hac_pkg::SPEED_W-1:0];
        hac_pkg::CFG_THRESHOLD:    angle_threshold_r <= cfg_wdata[hac_pkg::THRESH_W-1:0];
        hac_pkg::CFG_SETTLE:       settle_needed_r   <= cfg_wdata[hac_pkg::SETTLE_W-1:0];
        hac_pkg::CFG_ODOM_TIMEOUT: odom_timeout_r    <= cfg_wdata[hac_pkg::TICK_BITS-1:0];
        hac_pkg::CFG_RUN_TIMEOUT:  run_timeout_r     <= cfg_wdata[hac_pkg::TICK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      active_r   <= 1'b0;
      have_yaw_r <= 1'b0;
      yaw_r      <= '0;
      elapsed_r  <= '0;
      odom_age_r <= '0;
      settle_r   <= '0;
    end else begin
      item_v_r   <= item_v_nxt;
      out_v_r    <= out_v_nxt;
      active_r   <= active_nxt;
      have_yaw_r <= have_yaw_nxt;
      yaw_r      <= yaw_nxt;
      elapsed_r  <= elapsed_nxt;
      odom_age_r <= odom_age_nxt;
      settle_r   <= settle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_req_r <= hac_pkg::req_t'(in_tuser);
      item_yaw_r <= in_tdata[hac_pkg::ANGLE_W-1:0];
    end
    if (proc_go && gen) begin
      out_rate_r   <= rate;
      out_status_r <= status;
      out_fresh_r  <= fresh;
    end
  end

endmodule
